FILE: rtl/sbll_pkg.sv
`default_nettype none

package sbll_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int CMD_W = 4;
	localparam int ST_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_GET       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SET       = 4'd3;
	localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 4'd5;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_REVERSE   = 4'd8;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/sbll_ram.sv
`default_nettype none

// simple dual-port RAM, one write and one registered read
module sbll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/bounded_singly_linked_list.sv
`default_nettype none

// Sequencing: append, prepend, delete first and the error/no-op cases need no walk through
//   link memory; indexed commands walk toward the index and reverse walks the whole list,
//   each at one link a cycle.
// Throughput: one command at a time; the next one is taken the cycle after the result is
//   loaded, while that result may still be waiting to be taken.
// Reset: arst_n clears the list to empty at once; no memory clearing pass is needed.
module bounded_singly_linked_list #(
	parameter int CAPACITY   = sbll_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = sbll_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// command channel
	input  wire logic                               cmd_valid,
	output logic                                    cmd_stall,
	input  wire logic [sbll_pkg::CMD_W-1:0]         command,
	input  wire logic [$clog2(CAPACITY+1)-1:0]      position,
	input  wire logic signed [DATA_WIDTH-1:0]       item_value,
	// response channel
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic [sbll_pkg::ST_W-1:0]               status,
	output logic signed [DATA_WIDTH-1:0]            read_value,
	output logic [$clog2(CAPACITY+1)-1:0]           list_length,
	output logic signed [DATA_WIDTH-1:0]            first_value,
	output logic signed [DATA_WIDTH-1:0]            last_value
);

	// PW holds a slot number plus the null marker (CAPACITY), and also a count 0..CAPACITY.
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;   // decode, range checks, slot allocation
	localparam logic [3:0] S_WALK    = 4'd2;   // follow one link per cycle
	localparam logic [3:0] S_POST    = 4'd3;   // act on the slot the walk reached
	localparam logic [3:0] S_APP2    = 4'd4;   // hook new node behind old tail
	localparam logic [3:0] S_INS_RD  = 4'd5;   // new node takes predecessor's link
	localparam logic [3:0] S_INS_LNK = 4'd6;   // predecessor points at new node
	localparam logic [3:0] S_GET     = 4'd7;
	localparam logic [3:0] S_DF_RD   = 4'd8;   // next of old head arrives
	localparam logic [3:0] S_HD_RD   = 4'd9;   // new head data arrives
	localparam logic [3:0] S_TL_RD   = 4'd10;  // new tail data arrives
	localparam logic [3:0] S_DA_V    = 4'd11;  // victim slot arrives
	localparam logic [3:0] S_DA_W    = 4'd12;  // victim's successor arrives
	localparam logic [3:0] S_REV     = 4'd13;  // flip one link per cycle
	localparam logic [3:0] S_DONE    = 4'd14;

	// what to do once a walk ends
	localparam logic [2:0] OP_GET   = 3'd0;
	localparam logic [2:0] OP_SET   = 3'd1;
	localparam logic [2:0] OP_INS   = 3'd2;
	localparam logic [2:0] OP_DLAST = 3'd3;
	localparam logic [2:0] OP_DMID  = 3'd4;

	// control state
	logic [3:0]    state_q, state_d;
	logic [PW-1:0] head_q, head_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [PW-1:0] count_q, count_d;
	logic [PW-1:0] stk_q, stk_d;        // entries on the free-slot stack
	logic [PW-1:0] fresh_q, fresh_d;    // slots handed out at least once since reset
	logic          rsp_valid_q, rsp_valid_d;

	// per-transaction working registers
	logic [sbll_pkg::CMD_W-1:0] cmd_q, cmd_d;
	logic [PW-1:0]              pos_q, pos_d;
	logic [DATA_WIDTH-1:0]      val_q, val_d;
	logic [2:0]                 op_q, op_d;
	logic [PW-1:0]              cur_q, cur_d;
	logic [PW-1:0]              prev_q, prev_d;
	logic [PW-1:0]              aux_q, aux_d;
	logic [PW-1:0]              new_q, new_d;
	logic [PW-1:0]              steps_q, steps_d;
	logic [DATA_WIDTH-1:0]      hdat_q, hdat_d;   // cached head and tail values
	logic [DATA_WIDTH-1:0]      tdat_q, tdat_d;
	logic [sbll_pkg::ST_W-1:0]  st_q, st_d;
	logic [DATA_WIDTH-1:0]      rv_q, rv_d;

	// response register
	logic [sbll_pkg::ST_W-1:0] status_q, status_d;
	logic [DATA_WIDTH-1:0]     read_value_q, read_value_d;
	logic [PW-1:0]             list_length_q, list_length_d;
	logic [DATA_WIDTH-1:0]     first_value_q, first_value_d;
	logic [DATA_WIDTH-1:0]     last_value_q, last_value_d;

	// memory ports
	logic                  data_we;
	logic [SW-1:0]         data_waddr, data_raddr;
	logic [DATA_WIDTH-1:0] data_wdata, data_rdata;
	logic                  link_we;
	logic [SW-1:0]         link_waddr, link_raddr;
	logic [PW-1:0]         link_wdata, link_rdata;
	logic                  free_we;
	logic [SW-1:0]         free_waddr, free_raddr;
	logic [SW-1:0]         free_wdata, free_rdata;

	// decode helpers
	logic          accept;
	logic          full, empty;
	logic [PW-1:0] last_idx;
	logic [PW-1:0] new_slot;
	logic          do_app, do_pre, do_dfirst, do_dlast;
	logic          alloc_go, rel_go;
	logic [PW-1:0] rel_slot;
	logic          walk_go;
	logic [PW-1:0] walk_n;
	logic [2:0]    walk_op;

	sbll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	sbll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	sbll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	// Top of the free stack is read constantly; stk_q holds still from IDLE to DISP,
	// so the popped slot is ready in DISP.
	assign free_raddr = SW'(stk_q - PW'(1));

	assign full     = (count_q == NIL);
	assign empty    = (count_q == '0);
	assign last_idx = count_q - PW'(1);
	// Reuse released slots first, otherwise hand out the next never-used one.
	assign new_slot = (stk_q != '0) ? PW'(free_rdata) : fresh_q;

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign list_length = list_length_q;
	assign first_value = first_value_q;
	assign last_value  = last_value_q;

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		stk_d         = stk_q;
		fresh_d       = fresh_q;
		rsp_valid_d   = rsp_valid_q && rsp_stall;
		cmd_d         = cmd_q;
		pos_d         = pos_q;
		val_d         = val_q;
		op_d          = op_q;
		cur_d         = cur_q;
		prev_d        = prev_q;
		aux_d         = aux_q;
		new_d         = new_q;
		steps_d       = steps_q;
		hdat_d        = hdat_q;
		tdat_d        = tdat_q;
		st_d          = st_q;
		rv_d          = rv_q;
		status_d      = status_q;
		read_value_d  = read_value_q;
		list_length_d = list_length_q;
		first_value_d = first_value_q;
		last_value_d  = last_value_q;

		data_we    = 1'b0;
		data_waddr = '0;
		data_wdata = val_q;
		data_raddr = '0;
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = NIL;
		link_raddr = '0;
		free_we    = 1'b0;
		free_waddr = SW'(stk_q);
		free_wdata = '0;

		do_app    = 1'b0;
		do_pre    = 1'b0;
		do_dfirst = 1'b0;
		do_dlast  = 1'b0;
		alloc_go  = 1'b0;
		rel_go    = 1'b0;
		rel_slot  = head_q;
		walk_go   = 1'b0;
		walk_n    = '0;
		walk_op   = OP_GET;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d   = command;
					pos_d   = position;
					val_d   = item_value;
					st_d    = sbll_pkg::ST_OK;
					rv_d    = '0;
					state_d = S_DISP;
				end
			end

			S_DISP: begin
				state_d = S_DONE;
				case (cmd_q)
					sbll_pkg::CMD_APPEND: begin
						if (full) st_d = sbll_pkg::ST_FULL;
						else do_app = 1'b1;
					end
					sbll_pkg::CMD_PREPEND: begin
						if (full) st_d = sbll_pkg::ST_FULL;
						else do_pre = 1'b1;
					end
					sbll_pkg::CMD_GET, sbll_pkg::CMD_SET: begin
						if (pos_q >= count_q) begin
							st_d = sbll_pkg::ST_RANGE;
						end else begin
							walk_go = 1'b1;
							walk_n  = pos_q;
							walk_op = (cmd_q == sbll_pkg::CMD_GET) ? OP_GET : OP_SET;
						end
					end
					sbll_pkg::CMD_INSERT: begin
						// index equal to the length appends
						if (pos_q > count_q) begin
							st_d = sbll_pkg::ST_RANGE;
						end else if (full) begin
							st_d = sbll_pkg::ST_FULL;
						end else if (pos_q == '0) begin
							do_pre = 1'b1;
						end else if (pos_q == count_q) begin
							do_app = 1'b1;
						end else begin
							alloc_go = 1'b1;
							walk_go  = 1'b1;
							walk_n   = pos_q - PW'(1);
							walk_op  = OP_INS;
						end
					end
					sbll_pkg::CMD_DEL_FIRST: begin
						if (empty) st_d = sbll_pkg::ST_EMPTY;
						else do_dfirst = 1'b1;
					end
					sbll_pkg::CMD_DEL_LAST: begin
						if (empty) st_d = sbll_pkg::ST_EMPTY;
						else do_dlast = 1'b1;
					end
					sbll_pkg::CMD_DEL_AT: begin
						if (empty) begin
							st_d = sbll_pkg::ST_EMPTY;
						end else if (pos_q >= count_q) begin
							st_d = sbll_pkg::ST_RANGE;
						end else if (pos_q == '0) begin
							do_dfirst = 1'b1;
						end else if (pos_q == last_idx) begin
							do_dlast = 1'b1;
						end else begin
							walk_go = 1'b1;
							walk_n  = pos_q - PW'(1);
							walk_op = OP_DMID;
						end
					end
					sbll_pkg::CMD_REVERSE: begin
						if (empty) begin
							st_d = sbll_pkg::ST_EMPTY;
						end else begin
							link_raddr = SW'(head_q);
							cur_d      = head_q;
							prev_d     = NIL;
							steps_d    = count_q;
							state_d    = S_REV;
						end
					end
					default: begin
						// undefined commands do nothing
					end
				endcase

				if (do_app) begin
					alloc_go   = 1'b1;
					data_we    = 1'b1;
					data_waddr = SW'(new_slot);
					link_we    = 1'b1;
					link_waddr = SW'(new_slot);
					link_wdata = NIL;
					tdat_d     = val_q;
					if (empty) begin
						head_d  = new_slot;
						tail_d  = new_slot;
						hdat_d  = val_q;
						count_d = count_q + PW'(1);
					end else begin
						state_d = S_APP2;
					end
				end

				if (do_pre) begin
					alloc_go   = 1'b1;
					data_we    = 1'b1;
					data_waddr = SW'(new_slot);
					link_we    = 1'b1;
					link_waddr = SW'(new_slot);
					link_wdata = empty ? NIL : head_q;
					head_d     = new_slot;
					hdat_d     = val_q;
					count_d    = count_q + PW'(1);
					if (empty) begin
						tail_d = new_slot;
						tdat_d = val_q;
					end
				end

				// single entry: both delete forms just empty the list
				if ((do_dfirst || do_dlast) && (count_q == PW'(1))) begin
					rel_go  = 1'b1;
					head_d  = NIL;
					tail_d  = NIL;
					count_d = '0;
				end else if (do_dfirst) begin
					rel_go     = 1'b1;
					count_d    = count_q - PW'(1);
					link_raddr = SW'(head_q);
					state_d    = S_DF_RD;
				end else if (do_dlast) begin
					walk_go = 1'b1;
					walk_n  = count_q - PW'(2);
					walk_op = OP_DLAST;
				end

				if (walk_go) begin
					op_d = walk_op;
					if (walk_n == '0) begin
						cur_d   = head_q;
						state_d = S_POST;
					end else begin
						link_raddr = SW'(head_q);
						steps_d    = walk_n;
						state_d    = S_WALK;
					end
				end

				if (alloc_go) begin
					new_d = new_slot;
					if (stk_q != '0) stk_d = stk_q - PW'(1);
					else fresh_d = fresh_q + PW'(1);
				end
			end

			S_WALK: begin
				cur_d   = link_rdata;
				steps_d = steps_q - PW'(1);
				if (steps_q == PW'(1)) begin
					state_d = S_POST;
				end else begin
					link_raddr = SW'(link_rdata);
				end
			end

			S_POST: begin
				state_d = S_DONE;
				case (op_q)
					OP_GET: begin
						data_raddr = SW'(cur_q);
						state_d    = S_GET;
					end
					OP_SET: begin
						data_we    = 1'b1;
						data_waddr = SW'(cur_q);
						if (pos_q == '0) hdat_d = val_q;
						if (pos_q == last_idx) tdat_d = val_q;
					end
					OP_INS: begin
						link_raddr = SW'(cur_q);
						state_d    = S_INS_RD;
					end
					OP_DLAST: begin
						// cur_q is the entry before the tail
						link_we    = 1'b1;
						link_waddr = SW'(cur_q);
						link_wdata = NIL;
						rel_go     = 1'b1;
						rel_slot   = tail_q;
						tail_d     = cur_q;
						count_d    = count_q - PW'(1);
						data_raddr = SW'(cur_q);
						state_d    = S_TL_RD;
					end
					OP_DMID: begin
						link_raddr = SW'(cur_q);
						state_d    = S_DA_V;
					end
					default: begin
					end
				endcase
			end

			S_APP2: begin
				link_we    = 1'b1;
				link_waddr = SW'(tail_q);
				link_wdata = new_q;
				tail_d     = new_q;
				count_d    = count_q + PW'(1);
				state_d    = S_DONE;
			end

			S_INS_RD: begin
				link_we    = 1'b1;
				link_waddr = SW'(new_q);
				link_wdata = link_rdata;
				data_we    = 1'b1;
				data_waddr = SW'(new_q);
				state_d    = S_INS_LNK;
			end

			S_INS_LNK: begin
				link_we    = 1'b1;
				link_waddr = SW'(cur_q);
				link_wdata = new_q;
				count_d    = count_q + PW'(1);
				state_d    = S_DONE;
			end

			S_GET: begin
				rv_d    = data_rdata;
				state_d = S_DONE;
			end

			S_DF_RD: begin
				head_d     = link_rdata;
				data_raddr = SW'(link_rdata);
				state_d    = S_HD_RD;
			end

			S_HD_RD: begin
				hdat_d  = data_rdata;
				state_d = S_DONE;
			end

			S_TL_RD: begin
				tdat_d  = data_rdata;
				state_d = S_DONE;
			end

			S_DA_V: begin
				aux_d      = link_rdata;
				link_raddr = SW'(link_rdata);
				state_d    = S_DA_W;
			end

			S_DA_W: begin
				link_we    = 1'b1;
				link_waddr = SW'(cur_q);
				link_wdata = link_rdata;
				rel_go     = 1'b1;
				rel_slot   = aux_q;
				count_d    = count_q - PW'(1);
				state_d    = S_DONE;
			end

			S_REV: begin
				// link_rdata is the successor of cur_q; read of it overlaps the flip
				link_we    = 1'b1;
				link_waddr = SW'(cur_q);
				link_wdata = prev_q;
				link_raddr = SW'(link_rdata);
				prev_d     = cur_q;
				cur_d      = link_rdata;
				steps_d    = steps_q - PW'(1);
				if (steps_q == PW'(1)) begin
					head_d  = cur_q;
					tail_d  = head_q;
					hdat_d  = tdat_q;
					tdat_d  = hdat_q;
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d   = 1'b1;
					status_d      = st_q;
					read_value_d  = rv_q;
					list_length_d = count_q;
					first_value_d = empty ? '0 : hdat_q;
					last_value_d  = empty ? '0 : tdat_q;
					state_d       = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (rel_go) begin
			free_we    = 1'b1;
			free_wdata = SW'(rel_slot);
			stk_d      = stk_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			stk_q       <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			stk_q       <= stk_d;
			fresh_q     <= fresh_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q         <= cmd_d;
		pos_q         <= pos_d;
		val_q         <= val_d;
		op_q          <= op_d;
		cur_q         <= cur_d;
		prev_q        <= prev_d;
		aux_q         <= aux_d;
		new_q         <= new_d;
		steps_q       <= steps_d;
		hdat_q        <= hdat_d;
		tdat_q        <= tdat_d;
		st_q          <= st_d;
		rv_q          <= rv_d;
		status_q      <= status_d;
		read_value_q  <= read_value_d;
		list_length_q <= list_length_d;
		first_value_q <= first_value_d;
		last_value_q  <= last_value_d;
	end

`ifndef SYNTH
	// every slot handed out is either on the free stack or linked in the list
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((fresh_q - stk_q) == count_q))
		else $error("slot accounting broken");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(((count_q == '0) == (head_q == NIL)) && ((count_q == '0) == (tail_q == NIL))))
		else $error("head/tail pointers disagree with length");

	a_steps_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WALK) || (state_q == S_REV)) |-> (steps_q != '0))
		else $error("walk running with no steps left");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside completion");
`endif

endmodule

`default_nettype wire
